// File: design/imupd_pkg.sv
// imupd_pkg: shared types, codes and the fixed-point scaling function
// for the imu packet stream decoder; no dependencies
`timescale 1ns / 1ps

package imupd_pkg;

  // packet framing
  localparam logic [7:0] HEADER_MARK = 8'h55;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_GYRO   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;
  localparam logic [3:0] POS_FIRST   = 4'd0;
  localparam logic [3:0] POS_TYPE    = 4'd1;
  localparam logic [3:0] POS_CHECK   = 4'd10;

  // result kind codes
  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_GYRO  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  localparam int VALUE_W = 19;
  localparam int WORD_W  = 16;

  // decoded packet handed from front to back
  typedef struct packed {
    logic [1:0]               kind;
    logic signed [WORD_W-1:0] raw_x;
    logic signed [WORD_W-1:0] raw_y;
    logic signed [WORD_W-1:0] raw_z;
    logic signed [WORD_W-1:0] extra;
  } imupd_item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } imupd_qstat_t;

  // raw * m / 2^s rounded to nearest, ties toward plus infinity
  function automatic logic signed [VALUE_W-1:0] scale_axis(
    input logic signed [WORD_W-1:0] raw,
    input logic [1:0]               kind
  );
    logic signed [23:0] raw_ext;
    logic signed [23:0] prod;
    logic signed [23:0] shifted;
    raw_ext = {{8{raw[WORD_W-1]}}, raw};
    case (kind)
      KIND_ACCEL: begin
        prod    = raw_ext * 24'sd125;
        shifted = (prod + 24'sd8) >>> 4;
      end
      KIND_GYRO: begin
        prod    = raw_ext * 24'sd125;
        shifted = (prod + 24'sd64) >>> 7;
      end
      default: begin
        prod    = raw_ext * 24'sd45;
        shifted = (prod + 24'sd256) >>> 9;
      end
    endcase
    return shifted[VALUE_W-1:0];
  endfunction

endpackage

// File: design/imupd_front.sv
// imupd_front: byte framing, checksum and type classification
// depends on imupd_pkg
`timescale 1ns / 1ps

module imupd_front import imupd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         in_burst_start,
  input  logic [7:0]   in_byte,
  input  imupd_qstat_t qstat,
  output logic         push,
  output imupd_item_t  push_item
);

  logic [3:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       hdr_r, hdr_nxt;
  logic [7:0] type_r;
  logic [7:0] pay_r [8];

  logic       accept;
  logic [3:0] pos_eff;
  logic [2:0] pay_idx;
  logic [3:0] pay_off;
  logic       known;

  // only the checksum byte can produce an item, so only it waits on the queue
  assign in_ready = (pos_r != POS_CHECK) || !qstat.full;
  assign accept   = in_valid && in_ready;

  // realignment, and out-of-range positions restart the packet
  assign pos_eff = (in_burst_start || pos_r > POS_CHECK) ? POS_FIRST : pos_r;
  assign pay_off = pos_eff - 4'd2;
  assign pay_idx = pay_off[2:0];

  // position, running sum and header flag
  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    hdr_nxt = hdr_r;
    if (accept) begin
      if (pos_eff == POS_FIRST) begin
        pos_nxt = 4'd1;
        sum_nxt = in_byte;
        hdr_nxt = (in_byte == HEADER_MARK);
      end else if (pos_eff < POS_CHECK) begin
        pos_nxt = pos_eff + 4'd1;
        sum_nxt = sum_r + in_byte;
      end else begin
        pos_nxt = POS_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_FIRST;
      sum_r <= 8'd0;
      hdr_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      hdr_r <= hdr_nxt;
    end
  end

  // type and payload capture
  always_ff @(posedge clk) begin
    if (accept && pos_eff == POS_TYPE) begin
      type_r <= in_byte;
    end
    if (accept && pos_eff > POS_TYPE && pos_eff < POS_CHECK) begin
      pay_r[pay_idx] <= in_byte;
    end
  end

  // classification on the checksum byte
  always_comb begin
    known          = 1'b1;
    push_item.kind = KIND_ACCEL;
    push_item.raw_x = {pay_r[1], pay_r[0]};
    push_item.raw_y = {pay_r[3], pay_r[2]};
    push_item.raw_z = {pay_r[5], pay_r[4]};
    push_item.extra = {pay_r[7], pay_r[6]};
    case (type_r)
      TYPE_ACCEL: push_item.kind = KIND_ACCEL;
      TYPE_GYRO: begin
        push_item.kind  = KIND_GYRO;
        push_item.extra = '0;
      end
      TYPE_ANGLE: push_item.kind = KIND_ANGLE;
      default:    known = 1'b0;
    endcase
  end

  assign push = accept && (pos_eff == POS_CHECK) && hdr_r && (in_byte == sum_r) && known;

endmodule

// File: design/imupd_fifo.sv
// imupd_fifo: short register queue of decoded packets between front and back
// depends on imupd_pkg
`timescale 1ns / 1ps

module imupd_fifo import imupd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  imupd_item_t  push_item,
  input  logic         pop,
  output imupd_item_t  head_item,
  output imupd_qstat_t qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  imupd_item_t   mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == LAST) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == LAST) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  assign head_item   = mem_r[rd_r];
  assign qstat.full  = (cnt_r == FULL_CNT);
  assign qstat.empty = (cnt_r == '0);

endmodule

// File: design/imupd_back.sv
// imupd_back: fixed-point scaling and the registered result stage
// depends on imupd_pkg
`timescale 1ns / 1ps

module imupd_back import imupd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  imupd_qstat_t              qstat,
  input  imupd_item_t               head_item,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic signed [VALUE_W-1:0] out_x,
  output logic signed [VALUE_W-1:0] out_y,
  output logic signed [VALUE_W-1:0] out_z,
  output logic signed [WORD_W-1:0]  out_extra
);

  logic                      valid_r, valid_nxt;
  logic [1:0]                kind_r;
  logic signed [VALUE_W-1:0] x_r, y_r, z_r;
  logic signed [WORD_W-1:0]  extra_r;
  logic                      load;

  // the result register takes a new item whenever it is empty or being drained
  assign load      = !valid_r || out_ready;
  assign pop       = load && !qstat.empty;
  assign valid_nxt = load ? !qstat.empty : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // scale the three axes into the result register
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= head_item.kind;
      x_r     <= scale_axis(head_item.raw_x, head_item.kind);
      y_r     <= scale_axis(head_item.raw_y, head_item.kind);
      z_r     <= scale_axis(head_item.raw_z, head_item.kind);
      extra_r <= head_item.extra;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_extra = extra_r;

endmodule

// File: design/imu_packet_stream_decoder.sv
// imu_packet_stream_decoder: top level, front framing, packet queue, back scaling
// depends on imupd_pkg, imupd_front, imupd_fifo, imupd_back
`timescale 1ns / 1ps

// The decoder takes one received byte per clock and cuts the stream into
// 11-byte packets (header 0x55, type byte, four little-endian int16 words,
// 8-bit sum). A byte flagged with burst_start is taken as byte 0 of a new
// packet. Good packets of type 0x51, 0x52 or 0x53 give one result item with
// the three axes scaled to Q.4 (mg, deg/s, deg) and a raw fourth word (zero
// for type 0x52); all other packets give nothing. Bytes are accepted every
// cycle; the checksum byte of a packet is held off only while the
// FIFO_DEPTH-entry packet queue is full. When the output is free, a result
// becomes valid once its checksum byte is taken and the packet has passed
// through the packet queue into the output register; the back end scales a
// queued packet as it moves into the output register.

module imu_packet_stream_decoder import imupd_pkg::*; #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] burst_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [18:0] value_x, [37:19] value_y,
                                  // [56:38] value_z, [72:57] extra_word, zero pad
  output logic [1:0]  out_tuser   // [1:0] packet_kind
);

  logic         push, pop;
  imupd_item_t  push_item, head_item;
  imupd_qstat_t qstat;

  logic signed [VALUE_W-1:0] val_x, val_y, val_z;
  logic signed [WORD_W-1:0]  extra;

  // byte framing and classification
  imupd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_burst_start (in_tuser[0]),
    .in_byte        (in_tdata),
    .qstat          (qstat),
    .push           (push),
    .push_item      (push_item)
  );

  // packet queue
  imupd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  // scaling and result register
  imupd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_x     (val_x),
    .out_y     (val_y),
    .out_z     (val_z),
    .out_extra (extra)
  );

  // result packing
  assign out_tdata = {7'd0, extra, val_z, val_y, val_x};

endmodule

// File: verif/tb_imu_packet_stream_decoder.sv
// tb_imu_packet_stream_decoder: self-checking bench for the imu packet decoder,
// byte stream in with random gaps, decoded readings out with random stalls
// depends on imupd_pkg and imu_packet_stream_decoder
`timescale 1ns / 1ps

module tb_imu_packet_stream_decoder;
  import imupd_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_BYTES = 1770;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 400000;

  // how a generated packet is damaged
  typedef enum {FAULT_NONE, FAULT_HEADER, FAULT_CHECKSUM} fault_t;

  // one decoded reading as it should leave the block
  typedef struct {
    logic [1:0]         kind;
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic signed [18:0] z;
    logic signed [15:0] extra;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic [0:0]  in_tuser = 1'b0;    // [0] burst_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;          // [18:0] x, [37:19] y, [56:38] z, [72:57] extra
  logic [1:0]  out_tuser;          // [1:0] packet_kind

  reading_t pending_readings[$];
  int       mismatches = 0;
  int       sent_bytes = 0;
  logic     no_input_gaps = 1'b0;

  // framing state tracked alongside the block
  logic [3:0] rx_pos = POS_FIRST;
  logic [7:0] rx_sum = 8'h00;
  logic       hdr_ok = 1'b0;
  logic [7:0] pkt_type;
  logic [7:0] pkt_payload[8];

  imu_packet_stream_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // raw int16 to Q.4 in the unit of this kind, round half up
  function automatic logic signed [18:0] to_q4(input logic signed [15:0] raw,
                                               input logic [1:0] kind);
    int mul;
    int sh;
    int acc;
    case (kind)
      KIND_ACCEL: begin
        mul = 125;
        sh  = 4;
      end
      KIND_GYRO: begin
        mul = 125;
        sh  = 7;
      end
      default: begin
        mul = 45;
        sh  = 9;
      end
    endcase
    acc = (int'(raw) * mul + (1 << (sh - 1))) >>> sh;
    return acc[18:0];
  endfunction

  // advance framing by one accepted byte, queue a reading on a good packet
  function automatic void decode_byte(input logic burst, input logic [7:0] b);
    logic [3:0]         pos;
    logic [1:0]         kind;
    logic               known;
    logic signed [15:0] wx;
    logic signed [15:0] wy;
    logic signed [15:0] wz;
    logic signed [15:0] w3;
    reading_t           r;
    pos = (burst || rx_pos > POS_CHECK) ? POS_FIRST : rx_pos;
    if (pos == POS_FIRST) begin
      rx_sum = b;
      hdr_ok = (b == HEADER_MARK);
      rx_pos = POS_TYPE;
    end else if (pos != POS_CHECK) begin
      if (pos == POS_TYPE)
        pkt_type = b;
      else
        pkt_payload[3'(pos - 4'd2)] = b;
      rx_sum = rx_sum + b;
      rx_pos = pos + 4'd1;
    end else begin
      rx_pos = POS_FIRST;
      known  = 1'b1;
      kind   = KIND_ANGLE;
      case (pkt_type)
        TYPE_ACCEL: kind = KIND_ACCEL;
        TYPE_GYRO:  kind = KIND_GYRO;
        TYPE_ANGLE: kind = KIND_ANGLE;
        default:    known = 1'b0;
      endcase
      if (hdr_ok && b == rx_sum && known) begin
        wx = {pkt_payload[1], pkt_payload[0]};
        wy = {pkt_payload[3], pkt_payload[2]};
        wz = {pkt_payload[5], pkt_payload[4]};
        w3 = {pkt_payload[7], pkt_payload[6]};
        r.kind  = kind;
        r.x     = to_q4(wx, kind);
        r.y     = to_q4(wy, kind);
        r.z     = to_q4(wz, kind);
        r.extra = (kind == KIND_GYRO) ? 16'sd0 : w3;
        pending_readings.push_back(r);
      end
    end
  endfunction

  // input gap length: mostly none, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_input_gaps || roll < 60)
      return 0;
    else if (roll < 90)
      return $urandom_range(1, 3);
    else if (roll < 98)
      return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // send one byte, update the expected readings once it is taken
  task automatic send_rx_byte(input logic burst, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= burst;
    do @(posedge clk); while (!in_tready);
    decode_byte(burst, b);
    sent_bytes++;
  endtask

  // build an 11-byte packet and send its first nbytes bytes
  task automatic send_packet(input logic [7:0] type_code, input logic [15:0] w0,
                             input logic [15:0] w1, input logic [15:0] w2,
                             input logic [15:0] w3, input fault_t fault,
                             input int nbytes, input logic burst);
    logic [7:0] pkt[11];
    logic [7:0] sum;
    int         i;
    pkt[0] = HEADER_MARK;
    if (fault == FAULT_HEADER) begin
      do pkt[0] = 8'($urandom); while (pkt[0] == HEADER_MARK);
    end
    pkt[1] = type_code;
    {pkt[3], pkt[2]} = w0;
    {pkt[5], pkt[4]} = w1;
    {pkt[7], pkt[6]} = w2;
    {pkt[9], pkt[8]} = w3;
    sum = 8'h00;
    for (i = 0; i < 10; i++)
      sum = sum + pkt[i];
    pkt[10] = sum;
    if (fault == FAULT_CHECKSUM)
      pkt[10] = sum ^ 8'($urandom_range(1, 255));
    no_input_gaps = ($urandom_range(0, 3) == 0);
    for (i = 0; i < nbytes; i++)
      send_rx_byte((i == 0) ? burst : 1'b0, pkt[i]);
  endtask

  // random payload word, extremes now and then
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] known_type();
    case ($urandom_range(0, 2))
      0:       return TYPE_ACCEL;
      1:       return TYPE_GYRO;
      default: return TYPE_ANGLE;
    endcase
  endfunction

  function automatic logic [7:0] odd_type();
    logic [7:0] t;
    do t = 8'($urandom); while (t == TYPE_ACCEL || t == TYPE_GYRO || t == TYPE_ANGLE);
    return t;
  endfunction

  // each kind with range ends and rounding ties
  task automatic test_packet_kinds();
    send_packet(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'hFFF8, 16'h8000, FAULT_NONE, 11, 1'b1);
    send_packet(TYPE_GYRO, 16'h7FFF, 16'h0040, 16'hFFC0, 16'h1234, FAULT_NONE, 11, 1'b0);
    send_packet(TYPE_ANGLE, 16'h0100, 16'hFF00, 16'h8000, 16'h7FFF, FAULT_NONE, 11, 1'b0);
  endtask

  // partial packet dropped by a burst start
  task automatic test_realignment();
    send_packet(TYPE_ACCEL, 16'h0008, 16'hFFFF, 16'h0001, 16'h0000, FAULT_NONE, 4, 1'b0);
    send_packet(TYPE_GYRO, 16'h8000, 16'h0001, 16'hFFFF, 16'h5555, FAULT_NONE, 11, 1'b1);
  endtask

  // packets that must give nothing
  task automatic test_bad_packets();
    send_packet(odd_type(), 16'h1111, 16'h2222, 16'h3333, 16'h4444, FAULT_NONE, 11, 1'b0);
    send_packet(TYPE_ACCEL, 16'h1111, 16'h2222, 16'h3333, 16'h4444, FAULT_HEADER, 11, 1'b0);
    send_packet(TYPE_ANGLE, 16'h1111, 16'h2222, 16'h3333, 16'h4444, FAULT_CHECKSUM, 11, 1'b0);
  endtask

  // mostly well-formed packets, some damaged, truncated or plain noise
  task automatic test_random_stream();
    int   first;
    int   roll;
    int   n;
    logic realign;
    logic burst;
    first   = sent_bytes;
    realign = 1'b0;
    while (sent_bytes - first < RANDOM_BYTES) begin
      roll  = $urandom_range(0, 99);
      burst = realign | 1'($urandom_range(0, 1));
      if (roll < 70) begin
        send_packet(known_type(), rand_word(), rand_word(), rand_word(), rand_word(),
                    FAULT_NONE, 11, burst);
        realign = 1'b0;
      end else if (roll < 76) begin
        send_packet(odd_type(), rand_word(), rand_word(), rand_word(), rand_word(),
                    FAULT_NONE, 11, burst);
        realign = 1'b0;
      end else if (roll < 82) begin
        send_packet(known_type(), rand_word(), rand_word(), rand_word(), rand_word(),
                    FAULT_HEADER, 11, burst);
        realign = 1'b0;
      end else if (roll < 88) begin
        send_packet(known_type(), rand_word(), rand_word(), rand_word(), rand_word(),
                    FAULT_CHECKSUM, 11, burst);
        realign = 1'b0;
      end else if (roll < 94) begin
        send_packet(known_type(), rand_word(), rand_word(), rand_word(), rand_word(),
                    FAULT_NONE, $urandom_range(1, 10), burst);
        realign = 1'b1;
      end else begin
        n = $urandom_range(1, 15);
        repeat (n) send_rx_byte($urandom_range(0, 3) == 0, 8'($urandom));
        realign = 1'b1;
      end
    end
  endtask

  // result side back-pressure: long ready stretches, short and long stalls
  initial begin
    int roll;
    int n;
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        n = $urandom_range(1, 30);
        repeat (n) begin
          @(negedge clk);
          out_tready <= 1'b1;
        end
      end else begin
        n = (roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (n) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_reading(input reading_t r);
    compare_field("packet_kind", r.kind, out_tuser);
    compare_field("value_x", r.x, $signed(out_tdata[18:0]));
    compare_field("value_y", r.y, $signed(out_tdata[37:19]));
    compare_field("value_z", r.z, $signed(out_tdata[56:38]));
    compare_field("extra_word", r.extra, $signed(out_tdata[72:57]));
    compare_field("tdata pad", 0, out_tdata[79:73]);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected reading, expected none, got kind %0d tdata %h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        check_reading(pending_readings.pop_front());
      end
    end
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout, %0d readings still expected", $time, pending_readings.size());
    $display("tb_imu_packet_stream_decoder NOT OK");
    $finish;
  end

  // test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_packet_kinds();
    test_realignment();
    test_bad_packets();
    test_random_stream();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_readings.size() == 0)
      $display("tb_imu_packet_stream_decoder OK");
    else
      $display("tb_imu_packet_stream_decoder NOT OK");
    $finish;
  end

endmodule
